FILE: hdl/kvlog_pkg.sv
// ----------------------------------------------------------------------------
// kvlog_pkg
// shared types, constants and the crc-32c byte update for the log record
// parser
// ----------------------------------------------------------------------------
package kvlog_pkg;

  // header layout, byte offsets from the start of the record
  localparam int unsigned HdrBytes  = 21;
  localparam int unsigned OfsStamp  = 4;
  localparam int unsigned OfsFlag   = 12;
  localparam int unsigned OfsKeyLen = 13;
  localparam int unsigned OfsValLen = 17;

  // reflected castagnoli polynomial
  localparam logic [31:0] CRC_POLY = 32'h82F6_3B78;

  typedef enum logic [1:0] {
    PH_HEADER = 2'd0,
    PH_BODY   = 2'd1,
    PH_SKIP   = 2'd2
  } phase_t;

  localparam logic [1:0] KIND_KEY     = 2'd0;
  localparam logic [1:0] KIND_VALUE   = 2'd1;
  localparam logic [1:0] KIND_SUMMARY = 2'd2;

  localparam logic [1:0] STAT_OK         = 2'd0;
  localparam logic [1:0] STAT_INCOMPLETE = 2'd1;
  localparam logic [1:0] STAT_CORRUPT    = 2'd2;

  typedef struct packed {
    logic [1:0]  result_kind;
    logic [7:0]  payload_byte;
    logic [1:0]  record_status;
    logic [63:0] time_stamp;
    logic [7:0]  flag_value;
    logic [31:0] key_length;
    logic [31:0] value_length;
    logic        last_of_run;
  } res_t;

  // one byte through the crc, lsb first
  function automatic logic [31:0] crc_byte(input logic [31:0] crc_in,
                                           input logic [7:0]  b);
    logic [31:0] c;
    c = crc_in ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  function automatic res_t make_payload(input logic [1:0] kind,
                                        input logic [7:0] b);
    res_t r;
    r              = '0;
    r.result_kind  = kind;
    r.payload_byte = b;
    return r;
  endfunction

  function automatic res_t make_summary(input logic [1:0]  status,
                                        input logic [63:0] stamp,
                                        input logic [7:0]  flag,
                                        input logic [31:0] klen,
                                        input logic [31:0] vlen);
    res_t r;
    r               = '0;
    r.result_kind   = KIND_SUMMARY;
    r.record_status = status;
    r.time_stamp    = stamp;
    r.flag_value    = flag;
    r.key_length    = klen;
    r.value_length  = vlen;
    return r;
  endfunction

endpackage

FILE: hdl/kv_log_record_parse_crc32c_check.sv
// ----------------------------------------------------------------------------
// kv_log_record_parse_crc32c_check
// byte-wide parser for one key-value log record with crc-32c check
// ----------------------------------------------------------------------------
// the first result of a byte is registered and is on m_axis in the cycle after the byte's beat
// throughput: one input byte per cycle while m_axis is ready; a body byte that also
//   closes the record or the buffer yields two results, which holds the input
//   while the two-entry result buffer drains
// reset: rst (synchronous) returns to the header phase with the crc at all ones
//   and empties the result buffer; the parser also resets after end of buffer
module kv_log_record_parse_crc32c_check
  import kvlog_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  // input byte stream
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [7:0]   s_axis_tdata,   // [7:0] data_byte
  input  logic         s_axis_tlast,   // end_of_buffer
  // result stream
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // [7:0] payload_byte, [9:8] record_status, [73:10] time_stamp,
  // [81:74] flag_value, [113:82] key_length, [145:114] value_length,
  // [151:146] zero
  output logic [151:0] m_axis_tdata,
  output logic [1:0]   m_axis_tuser,   // [1:0] result_kind
  output logic         m_axis_tlast    // last_of_run
);

  // parser state
  phase_t      parse_phase, parse_phase_next;
  logic [4:0]  header_count, header_count_next;
  logic [31:0] stored_check, stored_check_next;
  logic [31:0] running_check, running_check_next;
  logic [63:0] stamp_reg, stamp_reg_next;
  logic [7:0]  flag_reg, flag_reg_next;
  logic [31:0] key_len_reg, key_len_reg_next;
  logic [31:0] value_len_reg, value_len_reg_next;
  logic [32:0] body_count, body_count_next;

  // result buffer: slot0 is presented, slot1 only ever holds a summary
  res_t        slot0, slot1;
  logic [1:0]  fill;

  // results made by the byte on the input this cycle
  res_t        res0, res1;
  logic [1:0]  res_n;

  logic        in_beat;
  logic        out_beat;
  logic        record_done;
  logic [7:0]  b;
  logic        eob;
  logic [4:0]  stamp_idx;
  logic [4:0]  klen_idx;
  logic [4:0]  vlen_idx;
  logic [32:0] body_total;
  logic [1:0]  fin_status;

  assign b   = s_axis_tdata;
  assign eob = s_axis_tlast;

  // a new byte may enter when the buffer is empty or empties this cycle
  assign s_axis_tready = (fill == 2'd0) || ((fill == 2'd1) && m_axis_tready);
  assign in_beat       = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = (fill != 2'd0);
  assign out_beat      = m_axis_tvalid && m_axis_tready;

  // byte positions within each little-endian header field
  assign stamp_idx  = header_count - 5'(OfsStamp);
  assign klen_idx   = header_count - 5'(OfsKeyLen);
  assign vlen_idx   = header_count - 5'(OfsValLen);
  assign body_total = {1'b0, key_len_reg} + {1'b0, value_len_reg};

  // next state and results for the byte at the input
  always_comb begin
    parse_phase_next   = parse_phase;
    header_count_next  = header_count;
    stored_check_next  = stored_check;
    running_check_next = running_check;
    stamp_reg_next     = stamp_reg;
    flag_reg_next      = flag_reg;
    key_len_reg_next   = key_len_reg;
    value_len_reg_next = value_len_reg;
    body_count_next    = body_count;
    res0               = '0;
    res1               = '0;
    res_n              = 2'd0;
    record_done        = 1'b0;
    fin_status         = STAT_OK;

    unique case (parse_phase)
      PH_HEADER: begin
        // scatter the byte into its header field
        if (header_count < 5'(OfsStamp)) begin
          stored_check_next = stored_check
                            | ({24'd0, b} << {header_count[1:0], 3'd0});
        end else if (header_count < 5'(OfsFlag)) begin
          stamp_reg_next = stamp_reg | ({56'd0, b} << {stamp_idx[2:0], 3'd0});
        end else if (header_count == 5'(OfsFlag)) begin
          flag_reg_next = b;
        end else if (header_count < 5'(OfsValLen)) begin
          key_len_reg_next = key_len_reg
                           | ({24'd0, b} << {klen_idx[1:0], 3'd0});
        end else if (header_count < 5'(HdrBytes)) begin
          value_len_reg_next = value_len_reg
                             | ({24'd0, b} << {vlen_idx[1:0], 3'd0});
        end
        // the stored crc itself is not covered
        if (header_count >= 5'(OfsStamp)) begin
          running_check_next = crc_byte(running_check, b);
        end
        header_count_next = header_count + 5'd1;
        fin_status = ((~running_check_next) == stored_check_next) ? STAT_OK
                                                                   : STAT_CORRUPT;
        // last header byte
        if (header_count >= 5'(HdrBytes - 1)) begin
          body_count_next = '0;
          if ((key_len_reg_next == '0) && (value_len_reg_next == '0)) begin
            // empty body closes the record right here
            res0        = make_summary(fin_status, stamp_reg_next, flag_reg_next,
                                       key_len_reg_next, value_len_reg_next);
            res_n       = 2'd1;
            record_done = 1'b1;
          end else begin
            parse_phase_next = PH_BODY;
          end
        end
        if (!record_done && eob) begin
          res0  = make_summary(STAT_INCOMPLETE, stamp_reg_next, flag_reg_next,
                               key_len_reg_next, value_len_reg_next);
          res_n = 2'd1;
        end
      end
      PH_BODY: begin
        res0  = make_payload((body_count < {1'b0, key_len_reg}) ? KIND_KEY
                                                                 : KIND_VALUE, b);
        res_n = 2'd1;
        running_check_next = crc_byte(running_check, b);
        body_count_next    = body_count + 33'd1;
        fin_status = ((~running_check_next) == stored_check) ? STAT_OK
                                                              : STAT_CORRUPT;
        if (body_count_next >= body_total) begin
          res1        = make_summary(fin_status, stamp_reg, flag_reg,
                                     key_len_reg, value_len_reg);
          res_n       = 2'd2;
          record_done = 1'b1;
        end else if (eob) begin
          res1  = make_summary(STAT_INCOMPLETE, stamp_reg, flag_reg,
                               key_len_reg, value_len_reg);
          res_n = 2'd2;
        end
      end
      default: begin
        // trailing bytes after the record give no result
      end
    endcase

    // flag the final result of this byte
    if (res_n == 2'd2) begin
      res1.last_of_run = 1'b1;
    end else if (res_n == 2'd1) begin
      res0.last_of_run = 1'b1;
    end

    if (eob) begin
      parse_phase_next   = PH_HEADER;
      header_count_next  = '0;
      stored_check_next  = '0;
      running_check_next = '1;
      stamp_reg_next     = '0;
      flag_reg_next      = '0;
      key_len_reg_next   = '0;
      value_len_reg_next = '0;
      body_count_next    = '0;
    end else if (record_done) begin
      parse_phase_next = PH_SKIP;
    end
  end

  // parser state register, advanced once per input beat
  always_ff @(posedge clk) begin
    if (rst) begin
      parse_phase   <= PH_HEADER;
      header_count  <= '0;
      stored_check  <= '0;
      running_check <= '1;
      stamp_reg     <= '0;
      flag_reg      <= '0;
      key_len_reg   <= '0;
      value_len_reg <= '0;
      body_count    <= '0;
    end else if (in_beat) begin
      parse_phase   <= parse_phase_next;
      header_count  <= header_count_next;
      stored_check  <= stored_check_next;
      running_check <= running_check_next;
      stamp_reg     <= stamp_reg_next;
      flag_reg      <= flag_reg_next;
      key_len_reg   <= key_len_reg_next;
      value_len_reg <= value_len_reg_next;
      body_count    <= body_count_next;
    end
  end

  // result buffer fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= 2'd0;
    end else if (in_beat) begin
      fill <= res_n;
    end else if (out_beat) begin
      fill <= fill - 2'd1;
    end
  end

  // result buffer payload
  always_ff @(posedge clk) begin
    if (in_beat) begin
      slot0 <= res0;
      slot1 <= res1;
    end else if (out_beat) begin
      slot0 <= slot1;
    end
  end

  assign m_axis_tuser = slot0.result_kind;
  assign m_axis_tlast = slot0.last_of_run;
  assign m_axis_tdata = {6'd0, slot0.value_length, slot0.key_length,
                         slot0.flag_value, slot0.time_stamp,
                         slot0.record_status, slot0.payload_byte};

endmodule

FILE: sim/kv_log_record_parse_crc32c_check_test.sv
// ----------------------------------------------------------------------------
// kv_log_record_parse_crc32c_check_test
// self-checking bench for the key-value log record parser: byte buffers built
// from records with good and bad crc-32c, cut short or padded with trailing
// bytes, plus raw noise, are streamed in under several idle and stall mixes;
// every result beat is checked against a bytewise parse done in the bench
// ----------------------------------------------------------------------------
module kv_log_record_parse_crc32c_check_test;
  import kvlog_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // one pending input beat
  typedef struct {
    logic [7:0] data;
    logic       last;
  } feed_beat_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [7:0]   s_axis_tdata = 8'd0;    // [7:0] data_byte
  logic         s_axis_tlast = 1'b0;    // end_of_buffer
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  // [7:0] payload_byte, [9:8] record_status, [73:10] time_stamp,
  // [81:74] flag_value, [113:82] key_length, [145:114] value_length, [151:146] zero
  logic [151:0] m_axis_tdata;
  logic [1:0]   m_axis_tuser;           // [1:0] result_kind
  logic         m_axis_tlast;           // last_of_run

  kv_log_record_parse_crc32c_check dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // stimulus bookkeeping
  feed_beat_t  byte_feed [$];
  int unsigned bytes_pushed   = 0;
  int unsigned bytes_accepted = 0;
  int unsigned record_bytes   = 0;     // bytes that reach the header or body
  int unsigned tx_idle_pct    = 0;
  int unsigned rx_stall_pct   = 0;
  bit          byte_taken     = 1'b0;  // input beat accepted at the last rising edge
  int unsigned fault_count    = 0;

  // bench copy of the parser state
  phase_t      rec_phase;
  logic [4:0]  hdr_pos;
  logic [31:0] crc_stored;
  logic [31:0] crc_run;
  logic [63:0] stamp_acc;
  logic [7:0]  flag_acc;
  logic [31:0] klen_acc;
  logic [31:0] vlen_acc;
  logic [32:0] body_pos;
  res_t        parsed_results [$];

  // reflected castagnoli, one byte, lsb first
  function automatic logic [31:0] crc32c_update(input logic [31:0] acc,
                                                input logic [7:0]  b);
    logic [31:0] c;
    c = acc ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = (c >> 1) ^ (CRC_POLY & {32{c[0]}});
    end
    return c;
  endfunction

  function automatic logic [1:0] crc_verdict();
    return (~crc_run == crc_stored) ? STAT_OK : STAT_CORRUPT;
  endfunction

  function automatic res_t summary_result(input logic [1:0] status);
    res_t r;
    r               = '0;
    r.result_kind   = KIND_SUMMARY;
    r.record_status = status;
    r.time_stamp    = stamp_acc;
    r.flag_value    = flag_acc;
    r.key_length    = klen_acc;
    r.value_length  = vlen_acc;
    return r;
  endfunction

  task automatic reset_parse_state();
    rec_phase  = PH_HEADER;
    hdr_pos    = '0;
    crc_stored = '0;
    crc_run    = '1;
    stamp_acc  = '0;
    flag_acc   = '0;
    klen_acc   = '0;
    vlen_acc   = '0;
    body_pos   = '0;
  endtask

  // advance the bench parser by one byte and queue the results it yields
  task automatic parse_record_byte(input logic [7:0] b, input logic eob);
    res_t        due [2];
    int          n;
    bit          done;
    logic [32:0] total;
    n    = 0;
    done = 1'b0;
    if (rec_phase == PH_HEADER) begin
      // little-endian header fields, crc field itself is not covered
      if (hdr_pos < OfsStamp) begin
        crc_stored = crc_stored | (32'(b) << (8 * hdr_pos));
      end else if (hdr_pos < OfsFlag) begin
        stamp_acc = stamp_acc | (64'(b) << (8 * (hdr_pos - OfsStamp)));
      end else if (hdr_pos == OfsFlag) begin
        flag_acc = b;
      end else if (hdr_pos < OfsValLen) begin
        klen_acc = klen_acc | (32'(b) << (8 * (hdr_pos - OfsKeyLen)));
      end else if (hdr_pos < HdrBytes) begin
        vlen_acc = vlen_acc | (32'(b) << (8 * (hdr_pos - OfsValLen)));
      end
      if (hdr_pos >= OfsStamp) crc_run = crc32c_update(crc_run, b);
      hdr_pos = hdr_pos + 5'd1;
      if (hdr_pos >= HdrBytes) begin
        body_pos = '0;
        // empty body: record closes on the last header byte
        if (klen_acc == 0 && vlen_acc == 0) begin
          due[n] = summary_result(crc_verdict());
          n++;
          done = 1'b1;
        end else begin
          rec_phase = PH_BODY;
        end
      end
      if (!done && eob) begin
        due[n] = summary_result(STAT_INCOMPLETE);
        n++;
      end
    end else if (rec_phase == PH_BODY) begin
      total                = {1'b0, klen_acc} + {1'b0, vlen_acc};
      due[n]               = '0;
      due[n].result_kind   = (body_pos < {1'b0, klen_acc}) ? KIND_KEY : KIND_VALUE;
      due[n].payload_byte  = b;
      n++;
      crc_run  = crc32c_update(crc_run, b);
      body_pos = body_pos + 33'd1;
      if (body_pos >= total) begin
        due[n] = summary_result(crc_verdict());
        n++;
        done = 1'b1;
      end else if (eob) begin
        due[n] = summary_result(STAT_INCOMPLETE);
        n++;
      end
    end
    // trailing bytes fall through here; end of buffer always restarts
    if (eob) begin
      reset_parse_state();
    end else if (done) begin
      rec_phase = PH_SKIP;
    end
    if (n > 0) due[n-1].last_of_run = 1'b1;
    for (int k = 0; k < n; k++) parsed_results.push_back(due[k]);
  endtask

  task automatic compare_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
    if (want !== got) begin
      fault_count++;
      if (fault_count <= 10) begin
        $display("%0t: %s mismatch, expected %0h, got %0h", $realtime, name, want, got);
      end
    end
  endtask

  // build one buffer: a record with the given header, nbytes long in total;
  // shorter than the record cuts it, longer adds trailing bytes
  task automatic send_buffer(input logic [63:0] stamp, input logic [7:0] flag,
                             input logic [31:0] klen, input logic [31:0] vlen,
                             input bit bad_crc, input int unsigned nbytes);
    logic [7:0]  hdr [21];
    logic [7:0]  body [$];
    logic [31:0] crc;
    logic [32:0] total;
    feed_beat_t  beat;
    total = {1'b0, klen} + {1'b0, vlen};
    for (int k = 0; k < 8; k++) hdr[OfsStamp + k] = stamp[8*k +: 8];
    hdr[OfsFlag] = flag;
    for (int k = 0; k < 4; k++) begin
      hdr[OfsKeyLen + k] = klen[8*k +: 8];
      hdr[OfsValLen + k] = vlen[8*k +: 8];
    end
    while (body.size() < nbytes && body.size() < total) body.push_back(8'($urandom));
    // crc covers header from the timestamp on, then the body
    crc = '1;
    for (int k = OfsStamp; k < HdrBytes; k++) crc = crc32c_update(crc, hdr[k]);
    foreach (body[k]) crc = crc32c_update(crc, body[k]);
    crc = ~crc;
    if (bad_crc) crc = crc ^ (32'd1 << $urandom_range(31));
    for (int k = 0; k < 4; k++) hdr[k] = crc[8*k +: 8];
    for (int unsigned k = 0; k < nbytes; k++) begin
      if (k < HdrBytes) begin
        beat.data = hdr[k];
      end else if (k - HdrBytes < body.size()) begin
        beat.data = body[k - HdrBytes];
      end else begin
        beat.data = 8'($urandom);
      end
      beat.last = (k == nbytes - 1);
      byte_feed.push_back(beat);
    end
    bytes_pushed += nbytes;
    record_bytes += (nbytes < HdrBytes + total) ? nbytes : 32'(HdrBytes + total);
  endtask

  // raw random bytes with end of buffer scattered in
  task automatic send_noise(input int unsigned n);
    feed_beat_t beat;
    for (int unsigned k = 0; k < n; k++) begin
      beat.data = 8'($urandom);
      beat.last = (k == n - 1) || ($urandom_range(7) == 0);
      byte_feed.push_back(beat);
    end
    bytes_pushed += n;
    record_bytes += n;
  endtask

  task automatic wait_drain();
    while (bytes_accepted != bytes_pushed || parsed_results.size() != 0) begin
      @(negedge clk);
    end
  endtask

  // driver: a new beat goes out at the falling edge once the previous one is taken
  always @(negedge clk) begin
    if (!rst && (!s_axis_tvalid || byte_taken)) begin
      if (byte_feed.size() > 0 && $urandom_range(99) >= tx_idle_pct) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= byte_feed[0].data;
        s_axis_tlast  <= byte_feed[0].last;
        byte_feed.delete(0);
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
    m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);
  end

  // monitor: results checked in order, accepted bytes fed to the bench parser
  always @(posedge clk) begin
    res_t want;
    byte_taken = 1'b0;
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (parsed_results.size() == 0) begin
          fault_count++;
          if (fault_count <= 10) begin
            $display("%0t: result beat with nothing due, kind %0d data %h",
                     $realtime, m_axis_tuser, m_axis_tdata);
          end
        end else begin
          want = parsed_results.pop_front();
          compare_field("result_kind", want.result_kind, m_axis_tuser);
          compare_field("payload_byte", want.payload_byte, m_axis_tdata[7:0]);
          compare_field("record_status", want.record_status, m_axis_tdata[9:8]);
          compare_field("time_stamp", want.time_stamp, m_axis_tdata[73:10]);
          compare_field("flag_value", want.flag_value, m_axis_tdata[81:74]);
          compare_field("key_length", want.key_length, m_axis_tdata[113:82]);
          compare_field("value_length", want.value_length, m_axis_tdata[145:114]);
          compare_field("tdata padding", 64'd0, m_axis_tdata[151:146]);
          compare_field("last_of_run", want.last_of_run, m_axis_tlast);
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        byte_taken = 1'b1;
        bytes_accepted++;
        parse_record_byte(s_axis_tdata, s_axis_tlast);
      end
    end
  end

  initial begin
    logic [31:0] klen;
    logic [31:0] vlen;
    int unsigned full;
    int unsigned nbytes;
    int unsigned pick;
    int unsigned phase_start;
    reset_parse_state();
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed buffers
    send_buffer(64'd0, 8'd0, 32'd0, 32'd0, 1'b0, 1);            // cut after one byte
    send_buffer('1, 8'hFF, 32'd0, 32'd0, 1'b0, HdrBytes);       // empty body, ends with buffer
    send_buffer(64'd0, 8'd0, 32'd0, 32'd0, 1'b1, HdrBytes + 3); // empty body, bad crc, trailing
    send_buffer({$urandom, $urandom}, 8'h5A, 32'd3, 32'd2, 1'b0, HdrBytes + 5);
    send_buffer({$urandom, $urandom}, 8'hA5, 32'd0, 32'd4, 1'b1, HdrBytes + 6);
    send_buffer({$urandom, $urandom}, 8'h01, 32'd2, 32'd0, 1'b0, HdrBytes + 3);
    send_buffer(64'd0, 8'd0, '1, '1, 1'b0, HdrBytes + 4);       // huge lengths, cut in body
    send_buffer({$urandom, $urandom}, 8'h80, 32'd1, 32'd1, 1'b0, HdrBytes); // cut at header end
    send_buffer({$urandom, $urandom}, 8'h7F, 32'd5, 32'd5, 1'b0, HdrBytes + 3); // cut in key

    // random part in four idle mixes
    for (int ph = 0; ph < 4; ph++) begin
      wait_drain();
      case (ph)
        0: begin
          tx_idle_pct  = 0;
          rx_stall_pct = 0;
        end
        1: begin
          tx_idle_pct  = 74;
          rx_stall_pct = 0;
        end
        2: begin
          tx_idle_pct  = 0;
          rx_stall_pct = 74;
        end
        default: begin
          tx_idle_pct  = 24;
          rx_stall_pct = 24;
        end
      endcase
      phase_start = record_bytes;
      while (record_bytes - phase_start < 120) begin
        pick = $urandom_range(99);
        klen = ($urandom_range(3) == 0) ? 32'd0 : 32'($urandom_range(6));
        vlen = ($urandom_range(3) == 0) ? 32'd0 : 32'($urandom_range(6));
        full = HdrBytes + klen + vlen;
        if (pick < 20) begin
          send_noise($urandom_range(1, 30));
        end else begin
          // whole records, records cut anywhere, and records with trailing bytes
          if (pick < 40) begin
            nbytes = $urandom_range(1, full - 1);
          end else if (pick < 70) begin
            nbytes = full;
          end else begin
            nbytes = full + $urandom_range(1, 4);
          end
          send_buffer({$urandom, $urandom}, 8'($urandom), klen, vlen,
                      $urandom_range(3) == 0, nbytes);
        end
      end
    end

    wait_drain();
    // give a stray extra result time to show up
    repeat (20) @(negedge clk);
    if (fault_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule

FILE: sim.f
hdl/kvlog_pkg.sv
hdl/kv_log_record_parse_crc32c_check.sv
sim/kv_log_record_parse_crc32c_check_test.sv
